>>> rtl/core/lbp_pkg.sv
// Shared types and constants for the LED blink pattern generator.
// No dependencies; used by every module in rtl/core.
package lbp_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [MsW-1:0] OffRecheckMs = MsW'(1000);
  localparam logic [MsW-1:0] AlarmOffMs   = MsW'(100);
  localparam logic [MsW-1:0] AlarmPauseMs = MsW'(600);

  // Requested / current pattern mode
  typedef enum logic [ModeW-1:0] {
    MODE_OFF      = 3'd0,
    MODE_DISARMED = 3'd1,
    MODE_ARMING   = 3'd2,
    MODE_ARMED    = 3'd3,
    MODE_ALARM    = 3'd4
  } mode_e;

  // Step phases (alarm uses all four, disarmed and armed the first two, others the first)
  typedef enum logic [PhaseW-1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_FOURTH = 2'd3
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISARMED_FLASH  = 4'd0,
    CFG_DISARMED_PERIOD = 4'd1,
    CFG_ARMING_HALF     = 4'd2,
    CFG_ARMED_ON        = 4'd3,
    CFG_ARMED_GAP       = 4'd4,
    CFG_ARMED_PAUSE     = 4'd5,
    CFG_ARMED_COUNT     = 4'd6,
    CFG_ALARM_ON        = 4'd7
  } cfg_idx_e;

  // Configuration bundle from the register file to the step engine
  typedef struct packed {
    logic [MsW-1:0]    disarmed_flash_ms;
    logic [MsW-1:0]    disarmed_period_ms;
    logic [MsW-1:0]    arming_half_ms;
    logic [MsW-1:0]    armed_on_ms;
    logic [MsW-1:0]    armed_gap_ms;
    logic [MsW-1:0]    armed_pause_ms;
    logic [CountW-1:0] armed_flash_count;
    logic [MsW-1:0]    alarm_on_ms;
  } cfg_t;

  // Hold of d ticks: next step due d ticks later; zero acts as one
  function automatic logic [MsW-1:0] hold_load(input logic [MsW-1:0] d);
    hold_load = (d == '0) ? '0 : d - MsW'(1);
  endfunction

endpackage

>>> rtl/core/lbp_cfg.sv
// Configuration register file for the LED blink pattern generator.
// Depends on lbp_pkg; writes beyond the last index are dropped.
module lbp_cfg import lbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MsW-1:0]     cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Always able to take a word
  assign cfg_ready_o = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DISARMED_FLASH:  cfg_d.disarmed_flash_ms  = cfg_data_i;
        CFG_DISARMED_PERIOD: cfg_d.disarmed_period_ms = cfg_data_i;
        CFG_ARMING_HALF:     cfg_d.arming_half_ms     = cfg_data_i;
        CFG_ARMED_ON:        cfg_d.armed_on_ms        = cfg_data_i;
        CFG_ARMED_GAP:       cfg_d.armed_gap_ms       = cfg_data_i;
        CFG_ARMED_PAUSE:     cfg_d.armed_pause_ms     = cfg_data_i;
        CFG_ARMED_COUNT:     cfg_d.armed_flash_count  = cfg_data_i[CountW-1:0];
        CFG_ALARM_ON:        cfg_d.alarm_on_ms        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disarmed_flash_ms  <= MsW'(50);
      cfg_q.disarmed_period_ms <= MsW'(6000);
      cfg_q.arming_half_ms     <= MsW'(100);
      cfg_q.armed_on_ms        <= MsW'(50);
      cfg_q.armed_gap_ms       <= MsW'(150);
      cfg_q.armed_pause_ms     <= MsW'(2000);
      cfg_q.armed_flash_count  <= CountW'(3);
      cfg_q.alarm_on_ms        <= MsW'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/lbp_step.sv
// Pattern step engine: mode, phase, flash count, hold counter and LED level.
// Depends on lbp_pkg; advances one tick per asserted tick_i.
module lbp_step import lbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic [ModeW-1:0] mode_i,
  input  cfg_t             cfg_i,
  output logic             led_o
);

  mode_e             mode_q, mode_d;
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] done_q, done_d;
  logic [MsW-1:0]    wait_q, wait_d;
  logic              led_q, led_d;

  // Working values after a possible mode switch
  mode_e             req_mode;
  phase_e            ph;
  logic [CountW-1:0] done, done_inc;
  logic [MsW-1:0]    wt, dis_off;
  logic              led;

  // Undefined codes fall back to off
  always_comb begin
    case (mode_e'(mode_i))
      MODE_DISARMED: req_mode = MODE_DISARMED;
      MODE_ARMING:   req_mode = MODE_ARMING;
      MODE_ARMED:    req_mode = MODE_ARMED;
      MODE_ALARM:    req_mode = MODE_ALARM;
      default:       req_mode = MODE_OFF;
    endcase
  end

  assign dis_off = (cfg_i.disarmed_period_ms > cfg_i.disarmed_flash_ms) ?
                   cfg_i.disarmed_period_ms - cfg_i.disarmed_flash_ms : '0;

  // One tick of the pattern
  always_comb begin
    ph       = phase_q;
    done     = done_q;
    wt       = wait_q;
    led      = led_q;
    // mode change restarts the pattern with a step due now
    if (req_mode != mode_q) begin
      ph   = PH_FIRST;
      done = '0;
      wt   = '0;
      led  = 1'b0;
    end
    done_inc = done + CountW'(1);

    mode_d  = req_mode;
    phase_d = ph;
    done_d  = done;
    led_d   = led;
    wait_d  = wt - MsW'(1);

    if (wt == '0) begin
      case (req_mode)
        MODE_DISARMED: begin
          if (ph == PH_FIRST) begin
            led_d   = 1'b1;
            wait_d  = hold_load(cfg_i.disarmed_flash_ms);
            phase_d = PH_SECOND;
          end else begin
            led_d   = 1'b0;
            wait_d  = hold_load(dis_off);
            phase_d = PH_FIRST;
          end
        end
        MODE_ARMING: begin
          led_d  = ~led;
          wait_d = hold_load(cfg_i.arming_half_ms);
        end
        MODE_ARMED: begin
          if (ph == PH_FIRST) begin
            led_d   = 1'b1;
            wait_d  = hold_load(cfg_i.armed_on_ms);
            phase_d = PH_SECOND;
          end else begin
            led_d   = 1'b0;
            phase_d = PH_FIRST;
            // gap between flashes, pause after the burst
            if (done_inc < cfg_i.armed_flash_count) begin
              done_d = done_inc;
              wait_d = hold_load(cfg_i.armed_gap_ms);
            end else begin
              done_d = '0;
              wait_d = hold_load(cfg_i.armed_pause_ms);
            end
          end
        end
        MODE_ALARM: begin
          case (ph)
            PH_FIRST: begin
              led_d = 1'b1; wait_d = hold_load(cfg_i.alarm_on_ms); phase_d = PH_SECOND;
            end
            PH_SECOND: begin
              led_d = 1'b0; wait_d = hold_load(AlarmOffMs); phase_d = PH_THIRD;
            end
            PH_THIRD: begin
              led_d = 1'b1; wait_d = hold_load(cfg_i.alarm_on_ms); phase_d = PH_FOURTH;
            end
            default: begin
              led_d = 1'b0; wait_d = hold_load(AlarmPauseMs); phase_d = PH_FIRST;
            end
          endcase
        end
        default: begin
          led_d  = 1'b0;
          wait_d = hold_load(OffRecheckMs);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      phase_q <= PH_FIRST;
      done_q  <= '0;
      wait_q  <= '0;
      led_q   <= 1'b0;
    end else if (tick_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      wait_q  <= wait_d;
      led_q   <= led_d;
    end
  end

  assign led_o = led_q;

endmodule

>>> rtl/core/led_blink_pattern_generator.sv
// LED blink pattern generator, top level: input register, step engine, result.
// Depends on lbp_pkg, lbp_cfg and lbp_step.
//
// One word in per millisecond tick carrying the requested mode, one word out
// with the LED level after that tick. The block takes a word every clock cycle
// unless its input side stalls; a tick is held in the input register, then the
// step engine (a compare, a decrement and a mode case) updates its state and the
// LED level register, which is the result word. The input side stalls only
// while a result is held by a stalled output. Configuration writes are always
// ready and take effect at once; write them only while idle.
module led_blink_pattern_generator import lbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tick input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ModeW-1:0]   req_mode_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               led_on_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MsW-1:0]     cfg_data_i
);

  logic             in_vld_q;
  logic [ModeW-1:0] in_mode_q;
  logic             out_vld_q, out_vld_d;
  logic             adv;
  cfg_t             cfg;

  // Word moves from input register to result when the result slot frees up
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign out_vld_d  = adv || (out_vld_q && out_stall_i);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_mode_q <= req_mode_i;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  lbp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // LED level register doubles as the result data; it only moves on adv
  lbp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (adv),
    .mode_i (in_mode_q),
    .cfg_i  (cfg),
    .led_o  (led_on_o)
  );

  assign out_valid_o = out_vld_q;

endmodule

>>> bench/tb_led_blink_pattern_generator.sv
// Self-checking bench for led_blink_pattern_generator: random mode ticks and
// register settings, with a scoreboard that predicts the LED level per tick.
// Depends on lbp_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_led_blink_pattern_generator;
  import lbp_pkg::*;

  localparam int unsigned WatchdogLimit    = 1000;
  localparam int unsigned FirstUnmappedIdx = int'(CFG_ALARM_ON) + 1;
  localparam int unsigned LastIdx          = (1 << CfgIdxW) - 1;
  localparam int unsigned FirstUndefMode   = int'(MODE_ALARM) + 1;
  localparam int unsigned LastUndefMode    = (1 << ModeW) - 1;

  // Predicts the LED level for every accepted tick and checks result words
  class led_pattern_scoreboard;
    logic [MsW-1:0]    dis_flash, dis_period, arming_half;
    logic [MsW-1:0]    armed_on, armed_gap, armed_pause, alarm_on;
    logic [CountW-1:0] armed_count;
    mode_e             mode;
    phase_e            phase;
    logic              led;
    logic [CountW-1:0] flashes_done;
    logic [MsW-1:0]    hold_left;
    bit                expected_led[$];
    int unsigned       mismatches;

    function new();
      dis_flash    = MsW'(50);
      dis_period   = MsW'(6000);
      arming_half  = MsW'(100);
      armed_on     = MsW'(50);
      armed_gap    = MsW'(150);
      armed_pause  = MsW'(2000);
      armed_count  = CountW'(3);
      alarm_on     = MsW'(100);
      mode         = MODE_OFF;
      phase        = PH_FIRST;
      led          = 1'b0;
      flashes_done = '0;
      hold_left    = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [MsW-1:0] data);
      case (idx)
        CFG_DISARMED_FLASH:  dis_flash = data;
        CFG_DISARMED_PERIOD: dis_period = data;
        CFG_ARMING_HALF:     arming_half = data;
        CFG_ARMED_ON:        armed_on = data;
        CFG_ARMED_GAP:       armed_gap = data;
        CFG_ARMED_PAUSE:     armed_pause = data;
        CFG_ARMED_COUNT:     armed_count = data[CountW-1:0];
        CFG_ALARM_ON:        alarm_on = data;
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    // next step due 'ticks' later; zero behaves like one
    function void load_hold(logic [MsW-1:0] ticks);
      hold_left = (ticks == '0) ? '0 : ticks - 1'b1;
    endfunction

    function void take_step();
      case (mode)
        MODE_DISARMED: begin
          if (phase == PH_FIRST) begin
            led = 1'b1;
            load_hold(dis_flash);
            phase = PH_SECOND;
          end else begin
            led = 1'b0;
            // off time clamps at zero when the period is shorter than the flash
            load_hold((dis_period > dis_flash) ? dis_period - dis_flash : '0);
            phase = PH_FIRST;
          end
        end
        MODE_ARMING: begin
          led = ~led;
          load_hold(arming_half);
        end
        MODE_ARMED: begin
          if (phase == PH_FIRST) begin
            led = 1'b1;
            load_hold(armed_on);
            phase = PH_SECOND;
          end else begin
            led = 1'b0;
            flashes_done = flashes_done + 1'b1;
            // a count of zero ends the burst after one flash
            if (flashes_done < armed_count) begin
              load_hold(armed_gap);
            end else begin
              load_hold(armed_pause);
              flashes_done = '0;
            end
            phase = PH_FIRST;
          end
        end
        MODE_ALARM: begin
          case (phase)
            PH_FIRST: begin
              led = 1'b1;
              load_hold(alarm_on);
            end
            PH_SECOND: begin
              led = 1'b0;
              load_hold(AlarmOffMs);
            end
            PH_THIRD: begin
              led = 1'b1;
              load_hold(alarm_on);
            end
            default: begin
              led = 1'b0;
              load_hold(AlarmPauseMs);
            end
          endcase
          phase = phase_e'(PhaseW'(int'(phase) + 1));
        end
        default: begin
          led = 1'b0;
          load_hold(OffRecheckMs);
        end
      endcase
    endfunction

    function void note_tick(logic [ModeW-1:0] req);
      mode_e want_mode;
      // undefined modes fall back to off
      want_mode = (req > MODE_ALARM) ? MODE_OFF : mode_e'(req);
      if (want_mode != mode) begin
        mode         = want_mode;
        phase        = PH_FIRST;
        flashes_done = '0;
        led          = 1'b0;
        hold_left    = '0;
      end
      if (hold_left == '0) begin
        take_step();
      end else begin
        hold_left = hold_left - 1'b1;
      end
      expected_led.push_back(led);
    endfunction

    function void check_led(logic actual);
      bit want;
      if (expected_led.size() == 0) begin
        $error("led_on: expected none, got %0b", actual);
        mismatches++;
      end else begin
        want = expected_led.pop_front();
        if (want !== actual) begin
          $error("led_on: expected %0b, got %0b", want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ModeW-1:0]   req_mode_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               led_on_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [MsW-1:0]     cfg_data_i = '0;

  led_pattern_scoreboard sb = new();
  logic [MsW-1:0] reg_plan [8];
  bit             steady = 1'b0;
  int unsigned    quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  led_blink_pattern_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_mode_i  (req_mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_on_o    (led_on_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Handshake monitor: feeds the scoreboard and runs the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(req_mode_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (out_valid_o && !out_stall_i) sb.check_led(led_on_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stall before each word
  initial begin
    int unsigned hold_off;
    forever begin
      @(negedge clk_i);
      hold_off = steady ? 0 : $urandom_range(0, 4);
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // One tick word, after a random gap
  task automatic send_tick(input logic [ModeW-1:0] m);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_mode_i <= m;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Runs of one mode with random length; short runs and undefined modes as noise
  task automatic run_ticks(input int n, input int max_run);
    int left;
    int run;
    logic [ModeW-1:0] m;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 6) == 0) begin
        m = ModeW'($urandom_range(FirstUndefMode, LastUndefMode));
      end else begin
        m = ModeW'($urandom_range(int'(MODE_OFF), int'(MODE_ALARM)));
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, max_run);
      if (run > left) run = left;
      repeat (run) send_tick(m);
      left -= run;
    end
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_led.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers from reg_plan, then one unmapped index
  task automatic apply_reg_plan();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= reg_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    @(negedge clk_i);
    cfg_index_i <= CfgIdxW'($urandom_range(FirstUnmappedIdx, LastIdx));
    cfg_data_i  <= MsW'($urandom);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Same hold on every timing register; count carries junk in its upper byte
  task automatic plan_uniform(input logic [MsW-1:0] hold, input logic [CountW-1:0] count);
    for (int i = 0; i < 8; i++) reg_plan[i] = hold;
    reg_plan[CFG_ARMED_COUNT] = {CountW'($urandom), count};
    apply_reg_plan();
  endtask

  task automatic plan_random(input int hold_max, input int count_lo, input int count_hi);
    for (int i = 0; i < 8; i++) reg_plan[i] = MsW'($urandom_range(0, hold_max));
    reg_plan[CFG_ARMED_COUNT] = {CountW'($urandom), CountW'($urandom_range(count_lo, count_hi))};
    apply_reg_plan();
  endtask

  // Main sequence
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: each mode in turn, then each undefined mode followed by an arming tick
    for (int k = int'(MODE_OFF); k <= int'(MODE_ALARM); k++) begin
      repeat ((k == int'(MODE_ALARM)) ? 4 : 3) send_tick(ModeW'(k));
    end
    for (int u = FirstUndefMode; u <= LastUndefMode; u++) begin
      send_tick(ModeW'(u));
      send_tick(MODE_ARMING);
    end
    wait_idle();

    // extremes: largest values, then all zero, then all one
    plan_uniform('1, '1);
    run_ticks(40, 8);
    wait_idle();
    plan_uniform('0, '0);
    run_ticks(100, 30);
    wait_idle();
    plan_uniform(MsW'(1), CountW'(1));
    steady = 1'b1;
    run_ticks(100, 30);
    wait_idle();

    // short holds so every pattern cycles many times
    for (int p = 0; p < 6; p++) begin
      plan_random(6, 0, 5);
      steady = (p % 3 == 2);
      run_ticks(100, 40);
      wait_idle();
    end

    // longer armed bursts
    plan_random(2, 8, 16);
    steady = 1'b0;
    run_ticks(80, 90);
    wait_idle();

    if (sb.mismatches == 0 && sb.expected_led.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_cfg.sv
rtl/core/lbp_step.sv
rtl/core/led_blink_pattern_generator.sv
bench/tb_led_blink_pattern_generator.sv
